>>> design/sphi_pkg.sv
// Package for the ray and unit sphere intersection block: field widths,
// request and result structs, and the lane records passed along the cell rows.
// Depends on nothing.
`default_nettype none
package sphi_pkg;

  // Coordinate format of the ray fields.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;

  // Fixed formats of the registers and the result.
  localparam int RSQ_W       = 32;
  localparam int RADIUS_FRAC = 24;
  localparam int MIN_W       = 16;
  localparam int OUT_FRAC    = 16;
  localparam int DIST_W      = 32;

  // Derived arithmetic widths.
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int A_W    = 2 * COORD_BITS;
  localparam int B_W    = 2 * COORD_BITS + 2;
  localparam int CD_W   = 2 * COORD_BITS + 1;
  localparam int CMAG_W = 2 * COORD_BITS;
  localparam int DISC_W = 4 * COORD_BITS;
  localparam int AR_W   = A_W + RSQ_W;
  localparam int SQ_N   = DISC_W / 2;
  localparam int NUM_W  = B_W + 1;
  localparam int THR_W  = MIN_W + 1 + A_W;
  localparam int R_SHIFT = 2 * FRAC_BITS - RADIUS_FRAC;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [RSQ_W-1:0]  RSQ_RESET = RSQ_W'(32'h0100_0000);
  localparam logic [MIN_W-1:0]  MIN_RESET = MIN_W'(7);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RADIUS_SQUARED = 1'b0,
    CFG_MIN_DISTANCE   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
  } in_req_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } out_res_t;

  // Record carried along the square root row, one bit pair per cell.
  typedef struct packed {
    logic                  ok;
    logic signed [B_W-1:0] b;
    logic [A_W-1:0]        a;
    logic [DISC_W-1:0]     x;
    logic [SQ_N+1:0]       rem;
    logic [SQ_N-1:0]       root;
  } sqrt_lane_t;

  // Record carried along the divider row, one quotient bit per cell.
  typedef struct packed {
    logic              hit;
    logic              sat;
    logic [A_W-1:0]    a;
    logic [DIST_W-1:0] d;
    logic [A_W:0]      rem;
    logic [DIST_W-1:0] q;
  } div_lane_t;

  // Brings r squared to the scale of the products of two coordinates.
  function automatic logic [RSQ_W-1:0] align_radius(input logic [RSQ_W-1:0] r);
    logic [RSQ_W-1:0] res;
    if (R_SHIFT >= 0) begin
      res = r << R_SHIFT;
    end else begin
      res = r >> (-R_SHIFT);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/sphi_sqrt_cell.sv
// One cell of the square root row: settles one root bit per cycle.
// Depends on sphi_pkg.
`default_nettype none
module sphi_sqrt_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                lane_vld_i,
  input  wire sphi_pkg::sqrt_lane_t lane_i,
  output logic                     lane_vld_o,
  output sphi_pkg::sqrt_lane_t     lane_o
);

  logic                  vld_r;
  sphi_pkg::sqrt_lane_t  lane_r, lane_nxt;
  logic [sphi_pkg::SQ_N+1:0] rem_t, trial;

  always_comb begin
    lane_nxt = lane_i;
    rem_t    = {lane_i.rem[sphi_pkg::SQ_N-1:0], lane_i.x[sphi_pkg::DISC_W-1 -: 2]};
    trial    = {lane_i.root, 2'b01};
    lane_nxt.x = lane_i.x << 2;
    if (rem_t >= trial) begin
      lane_nxt.rem  = rem_t - trial;
      lane_nxt.root = {lane_i.root[sphi_pkg::SQ_N-2:0], 1'b1};
    end else begin
      lane_nxt.rem  = rem_t;
      lane_nxt.root = {lane_i.root[sphi_pkg::SQ_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= lane_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_vld_o = vld_r;
  assign lane_o     = lane_r;

endmodule
`default_nettype wire

>>> design/sphi_div_cell.sv
// One cell of the restoring divider row: settles one quotient bit per cycle.
// Depends on sphi_pkg.
`default_nettype none
module sphi_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               lane_vld_i,
  input  wire sphi_pkg::div_lane_t lane_i,
  output logic                    lane_vld_o,
  output sphi_pkg::div_lane_t     lane_o
);

  logic                 vld_r;
  sphi_pkg::div_lane_t  lane_r, lane_nxt;
  logic [sphi_pkg::A_W:0] rem_t;

  always_comb begin
    lane_nxt   = lane_i;
    rem_t      = {lane_i.rem[sphi_pkg::A_W-1:0], lane_i.d[sphi_pkg::DIST_W-1]};
    lane_nxt.d = lane_i.d << 1;
    if (rem_t >= {1'b0, lane_i.a}) begin
      lane_nxt.rem = rem_t - {1'b0, lane_i.a};
      lane_nxt.q   = {lane_i.q[sphi_pkg::DIST_W-2:0], 1'b1};
    end else begin
      lane_nxt.rem = rem_t;
      lane_nxt.q   = {lane_i.q[sphi_pkg::DIST_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= lane_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_vld_o = vld_r;
  assign lane_o     = lane_r;

endmodule
`default_nettype wire

>>> design/ray_unit_sphere_intersect.sv
// Top level of the ray and sphere intersection block: front products, the
// square root and divider cell rows, root selection and the result register.
// Depends on sphi_pkg, sphi_sqrt_cell and sphi_div_cell.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-------------------------------
//   request  | start, busy, in_data           | taken when start && !busy
//   result   | out_valid, out_data            | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// A request is accepted in every cycle; busy is always low. Each result
// passes in order through the product and sum stages, 32 square root
// cells, the root selection stages, 32 divider cells and the output
// register. The two cell rows are the longest part of this path.
// Reset is synchronous and active low; it empties the pipeline and loads the
// unit sphere radius and the default epsilon. The receiver cannot stall.
`default_nettype none
module ray_unit_sphere_intersect (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sphi_pkg::in_req_t           in_data,
  output logic                             out_valid,
  output sphi_pkg::out_res_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [sphi_pkg::RSQ_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [sphi_pkg::RSQ_W-1:0] rsq_r;
  logic [sphi_pkg::MIN_W-1:0] min_dist_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsq_r      <= sphi_pkg::RSQ_RESET;
      min_dist_r <= sphi_pkg::MIN_RESET;
    end else if (cfg_valid) begin
      unique case (sphi_pkg::cfg_idx_t'(cfg_index))
        sphi_pkg::CFG_RADIUS_SQUARED: rsq_r <= cfg_data;
        sphi_pkg::CFG_MIN_DISTANCE:   min_dist_r <= cfg_data[sphi_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages.
  logic [4:0] fvld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= '0;
    end else begin
      fvld_r <= {fvld_r[3:0], start};
    end
  end

  // Stage one: the twelve coordinate products.
  logic signed [sphi_pkg::PROD_W-1:0] dxx_r, dyy_r, dzz_r, oxdx_r, oydy_r, ozdz_r;
  logic signed [sphi_pkg::PROD_W-1:0] oydz_r, ozdy_r, ozdx_r, oxdz_r, oxdy_r, oydx_r;

  always_ff @(posedge clk) begin
    dxx_r  <= in_data.dir_x * in_data.dir_x;
    dyy_r  <= in_data.dir_y * in_data.dir_y;
    dzz_r  <= in_data.dir_z * in_data.dir_z;
    oxdx_r <= in_data.origin_x * in_data.dir_x;
    oydy_r <= in_data.origin_y * in_data.dir_y;
    ozdz_r <= in_data.origin_z * in_data.dir_z;
    oydz_r <= in_data.origin_y * in_data.dir_z;
    ozdy_r <= in_data.origin_z * in_data.dir_y;
    ozdx_r <= in_data.origin_z * in_data.dir_x;
    oxdz_r <= in_data.origin_x * in_data.dir_z;
    oxdy_r <= in_data.origin_x * in_data.dir_y;
    oydx_r <= in_data.origin_y * in_data.dir_x;
  end

  // Stage two: A, B and the magnitudes of the cross product o x d.
  logic [sphi_pkg::A_W-1:0]          a2_r;
  logic signed [sphi_pkg::B_W-1:0]   b2_r;
  logic [sphi_pkg::CMAG_W-1:0]       cmx_r, cmy_r, cmz_r;
  logic signed [sphi_pkg::CD_W-1:0]  cx, cy, cz;

  function automatic logic [sphi_pkg::CMAG_W-1:0] mag(input logic signed [sphi_pkg::CD_W-1:0] v);
    logic signed [sphi_pkg::CD_W-1:0] p;
    p = v[sphi_pkg::CD_W-1] ? -v : v;
    return p[sphi_pkg::CMAG_W-1:0];
  endfunction

  always_comb begin
    cx = sphi_pkg::CD_W'(oydz_r) - sphi_pkg::CD_W'(ozdy_r);
    cy = sphi_pkg::CD_W'(ozdx_r) - sphi_pkg::CD_W'(oxdz_r);
    cz = sphi_pkg::CD_W'(oxdy_r) - sphi_pkg::CD_W'(oydx_r);
  end

  always_ff @(posedge clk) begin
    a2_r  <= sphi_pkg::A_W'($unsigned(dxx_r)) + sphi_pkg::A_W'($unsigned(dyy_r))
           + sphi_pkg::A_W'($unsigned(dzz_r));
    b2_r  <= sphi_pkg::B_W'(oxdx_r) + sphi_pkg::B_W'(oydy_r) + sphi_pkg::B_W'(ozdz_r);
    cmx_r <= mag(cx);
    cmy_r <= mag(cy);
    cmz_r <= mag(cz);
  end

  // Stage three: squares of the cross product terms and A times r squared.
  // The discriminant is formed as A*r^2 - |o x d|^2, which equals B^2 - A*C.
  logic [sphi_pkg::DISC_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic [sphi_pkg::AR_W-1:0]       ar3_r;
  logic [sphi_pkg::A_W-1:0]        a3_r;
  logic signed [sphi_pkg::B_W-1:0] b3_r;

  always_ff @(posedge clk) begin
    sqx_r <= cmx_r * cmx_r;
    sqy_r <= cmy_r * cmy_r;
    sqz_r <= cmz_r * cmz_r;
    ar3_r <= a2_r * sphi_pkg::align_radius(rsq_r);
    a3_r  <= a2_r;
    b3_r  <= b2_r;
  end

  // Stage four: sum of the cross product squares.
  logic [sphi_pkg::DISC_W-1:0]     cross2_r, ar4_r;
  logic [sphi_pkg::A_W-1:0]        a4_r;
  logic signed [sphi_pkg::B_W-1:0] b4_r;

  always_ff @(posedge clk) begin
    cross2_r <= sqx_r + sqy_r + sqz_r;
    ar4_r    <= sphi_pkg::DISC_W'(ar3_r);
    a4_r     <= a3_r;
    b4_r     <= b3_r;
  end

  // Stage five: discriminant and its sign; feeds the square root row.
  sphi_pkg::sqrt_lane_t sq_lane [0:sphi_pkg::SQ_N];
  logic                 sq_vld  [0:sphi_pkg::SQ_N];
  sphi_pkg::sqrt_lane_t sq_head_r;

  always_ff @(posedge clk) begin
    sq_head_r.ok   <= (a4_r != '0) && (ar4_r >= cross2_r);
    sq_head_r.b    <= b4_r;
    sq_head_r.a    <= a4_r;
    sq_head_r.x    <= ar4_r - cross2_r;
    sq_head_r.rem  <= '0;
    sq_head_r.root <= '0;
  end

  assign sq_lane[0] = sq_head_r;
  assign sq_vld[0]  = fvld_r[4];

  for (genvar i = 0; i < sphi_pkg::SQ_N; i++) begin : g_sqrt
    sphi_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_vld_i (sq_vld[i]),
      .lane_i     (sq_lane[i]),
      .lane_vld_o (sq_vld[i+1]),
      .lane_o     (sq_lane[i+1])
    );
  end

  // Selection stage one: numerators of the two roots, in the scale of B.
  sphi_pkg::sqrt_lane_t              sq_tail;
  logic signed [sphi_pkg::NUM_W-1:0] near1_r, far1_r, negb;
  logic [sphi_pkg::A_W-1:0]          a1_r;
  logic                              ok1_r;

  assign sq_tail = sq_lane[sphi_pkg::SQ_N];
  assign negb    = -sphi_pkg::NUM_W'(sq_tail.b);

  always_ff @(posedge clk) begin
    near1_r <= negb - $signed(sphi_pkg::NUM_W'(sq_tail.root));
    far1_r  <= negb + $signed(sphi_pkg::NUM_W'(sq_tail.root));
    a1_r    <= sq_tail.a;
    ok1_r   <= sq_tail.ok;
  end

  // Selection stage two: threshold (epsilon + 1) * A. A quotient exceeds
  // epsilon exactly when the scaled numerator reaches this threshold.
  logic signed [sphi_pkg::NUM_W-1:0] near2_r, far2_r;
  logic [sphi_pkg::A_W-1:0]          a2s_r;
  logic                              ok2_r;
  logic [sphi_pkg::THR_W-1:0]        thr_r;

  always_ff @(posedge clk) begin
    thr_r   <= ({1'b0, min_dist_r} + (sphi_pkg::MIN_W+1)'(1)) * a1_r;
    near2_r <= near1_r;
    far2_r  <= far1_r;
    a2s_r   <= a1_r;
    ok2_r   <= ok1_r;
  end

  // Selection stage three: accept the nearer root if it passes, else the
  // farther one, and flag a quotient that would not fit in the distance.
  localparam int SC_W = sphi_pkg::NUM_W + sphi_pkg::OUT_FRAC;

  logic [SC_W-1:0] near_sc, far_sc, thr_x, a_sh;
  logic            near_ok, far_ok;
  logic [sphi_pkg::NUM_W-1:0] pick;
  sphi_pkg::div_lane_t dv_head_r;

  always_comb begin
    near_sc = {near2_r, {sphi_pkg::OUT_FRAC{1'b0}}};
    far_sc  = {far2_r,  {sphi_pkg::OUT_FRAC{1'b0}}};
    thr_x   = SC_W'(thr_r);
    a_sh    = SC_W'({a2s_r, {sphi_pkg::OUT_FRAC{1'b0}}});
    near_ok = !near2_r[sphi_pkg::NUM_W-1] && (near2_r != '0) && (near_sc >= thr_x);
    far_ok  = !far2_r[sphi_pkg::NUM_W-1]  && (far2_r != '0)  && (far_sc >= thr_x);
    pick    = near_ok ? near2_r : far2_r;
  end

  always_ff @(posedge clk) begin
    dv_head_r.hit <= ok2_r && (near_ok || far_ok);
    dv_head_r.sat <= SC_W'(pick) >= a_sh;
    dv_head_r.a   <= a2s_r;
    dv_head_r.rem <= (sphi_pkg::A_W+1)'(pick >> sphi_pkg::OUT_FRAC);
    dv_head_r.d   <= {pick[sphi_pkg::OUT_FRAC-1:0],
                      {(sphi_pkg::DIST_W-sphi_pkg::OUT_FRAC){1'b0}}};
    dv_head_r.q   <= '0;
  end

  // Selection valid bits.
  logic [2:0] svld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svld_r <= '0;
    end else begin
      svld_r <= {svld_r[1:0], sq_vld[sphi_pkg::SQ_N]};
    end
  end

  sphi_pkg::div_lane_t dv_lane [0:sphi_pkg::DIST_W];
  logic                dv_vld  [0:sphi_pkg::DIST_W];

  assign dv_lane[0] = dv_head_r;
  assign dv_vld[0]  = svld_r[2];

  for (genvar j = 0; j < sphi_pkg::DIST_W; j++) begin : g_div
    sphi_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_vld_i (dv_vld[j]),
      .lane_i     (dv_lane[j]),
      .lane_vld_o (dv_vld[j+1]),
      .lane_o     (dv_lane[j+1])
    );
  end

  // Result register: saturate, and give zero distance on a miss.
  sphi_pkg::div_lane_t dv_tail;
  logic                out_valid_r;
  sphi_pkg::out_res_t  out_data_r;

  assign dv_tail = dv_lane[sphi_pkg::DIST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[sphi_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.hit      <= dv_tail.hit;
    out_data_r.distance <= !dv_tail.hit ? '0 :
                           (dv_tail.sat ? sphi_pkg::DIST_MAX : dv_tail.q);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A miss always carries a zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.distance == '0)
    else $error("miss with non-zero distance");

  // A hit lies strictly beyond epsilon.
  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |->
      out_data.distance > sphi_pkg::DIST_W'(min_dist_r))
    else $error("hit at or below epsilon");

  // The square root remainder never exceeds twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld[sphi_pkg::SQ_N] |-> sq_tail.rem <= {1'b0, sq_tail.root, 1'b0})
    else $error("square root remainder out of range");

  // An unsaturated quotient leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[sphi_pkg::DIST_W] && dv_tail.hit && !dv_tail.sat |->
      dv_tail.rem < {1'b0, dv_tail.a})
    else $error("divider remainder out of range");

endmodule
`default_nettype wire

>>> sim/ray_unit_sphere_intersect_tb.sv
// Testbench for ray_unit_sphere_intersect: drives rays through the request port,
// predicts each hit and distance in fixed point and checks every result strobe.
// Depends on sphi_pkg and the ray_unit_sphere_intersect RTL.
`timescale 1ns / 100ps
module ray_unit_sphere_intersect_tb;

  // Pipeline depth of the top level; DRAIN adds a margin to it.
  localparam int LATENCY = 73;
  localparam int DRAIN   = LATENCY + 20;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  sphi_pkg::in_req_t          in_data;
  logic                       out_valid;
  sphi_pkg::out_res_t         out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [0:0]                 cfg_index;
  logic [sphi_pkg::RSQ_W-1:0] cfg_data;

  ray_unit_sphere_intersect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor's own copy of the two registers.
  logic [sphi_pkg::RSQ_W-1:0] model_rsq;
  logic [sphi_pkg::MIN_W-1:0] model_eps;

  sphi_pkg::in_req_t  ray_queue[$];   // rays waiting to be offered
  sphi_pkg::out_res_t hit_queue[$];   // predicted hits, oldest first
  int                 errors;
  bit                 drive_enable;   // driver may offer rays
  bit                 idle_enable;    // random gaps in the sender
  bit                 cfg_go;
  sphi_pkg::cfg_idx_t cfg_sel;
  logic [sphi_pkg::RSQ_W-1:0] cfg_val;
  bit                 cfg_done;
  int                 gap_left;

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Integer floor square root by the bit pair method.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Tests one root: numerator in the scale of B, quotient in Q16.16.
  function automatic bit accept_root(input logic [63:0] num, input logic [63:0] a,
                                     output logic [31:0] dist_q);
    logic [63:0] q;
    dist_q = '0;
    if (num == 0 || num[63]) return 1'b0;
    if (num > (64'hFFFF_FFFF_FFFF_FFFF >> sphi_pkg::OUT_FRAC)) q = 64'hFFFF_FFFF;
    else q = (num << sphi_pkg::OUT_FRAC) / a;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    if (q <= {48'd0, model_eps}) return 1'b0;
    dist_q = q[31:0];
    return 1'b1;
  endfunction

  // Works out the nearer accepted intersection of one ray with the sphere.
  function automatic sphi_pkg::out_res_t sphere_hit(input sphi_pkg::in_req_t ray);
    logic signed [63:0] ox, oy, oz, dx, dy, dz;
    logic [63:0] a, b, cx, cy, cz, cross2, r, ar, disc, s, negb;
    logic [31:0] dist_q;
    sphi_pkg::out_res_t res;
    ox = ray.origin_x; oy = ray.origin_y; oz = ray.origin_z;
    dx = ray.dir_x;    dy = ray.dir_y;    dz = ray.dir_z;
    a  = dx * dx + dy * dy + dz * dz;
    b  = ox * dx + oy * dy + oz * dz;
    cx = oy * dz - oz * dy;
    cy = oz * dx - ox * dz;
    cz = ox * dy - oy * dx;
    cross2 = cx * cx + cy * cy + cz * cz;
    // With 12 fraction bits the products already have the radius's 24.
    if (2 * sphi_pkg::FRAC_BITS >= sphi_pkg::RADIUS_FRAC)
      r = {32'd0, model_rsq} << (2 * sphi_pkg::FRAC_BITS - sphi_pkg::RADIUS_FRAC);
    else
      r = {32'd0, model_rsq} >> (sphi_pkg::RADIUS_FRAC - 2 * sphi_pkg::FRAC_BITS);
    res = '0;
    dist_q = '0;
    if (a != 0) begin
      ar = a * r;
      if (ar >= cross2) begin
        disc = ar - cross2;
        s = floor_sqrt(disc);
        negb = 64'd0 - b;
        res.hit = accept_root(negb - s, a, dist_q);
        if (!res.hit) res.hit = accept_root(negb + s, a, dist_q);
      end
    end
    res.distance = res.hit ? dist_q : '0;
    return res;
  endfunction

  // Driver: offers queued rays with random idle bursts. A request is taken
  // at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        hit_queue.push_back(sphere_hit(in_data));
      end
      if (start && busy) begin
        // Hold the current request until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (drive_enable && ray_queue.size() > 0 &&
                   !(idle_enable && $urandom_range(0, 9) == 0)) begin
        start   <= 1'b1;
        in_data <= ray_queue.pop_front();
      end else begin
        start <= 1'b0;
        if (idle_enable && drive_enable && ray_queue.size() > 0)
          gap_left <= $urandom_range(1, 8) - 1;
      end
    end
  end

  // Configuration writer: one register write per request from the sequence.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
      cfg_done  <= 1'b0;
    end else begin
      cfg_done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sphi_pkg::CFG_RADIUS_SQUARED) model_rsq = cfg_data;
        else model_eps = cfg_data[sphi_pkg::MIN_W-1:0];
        cfg_valid <= 1'b0;
        cfg_done  <= 1'b1;
      end else if (cfg_go && !cfg_valid && !cfg_done) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_sel;
        cfg_data  <= cfg_val;
      end
    end
  end

  // Monitor: every strobe is compared with the oldest prediction.
  always @(posedge clk) begin
    sphi_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%08h",
                 $realtime, out_data.hit, out_data.distance);
        errors++;
      end else begin
        want = hit_queue.pop_front();
        if (out_data.hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b",
                   $realtime, want.hit, out_data.hit);
          errors++;
        end
        if (out_data.distance !== want.distance) begin
          $display("%0t: distance mismatch: expected %08h, actual %08h",
                   $realtime, want.distance, out_data.distance);
          errors++;
        end
      end
    end
  end

  function automatic sphi_pkg::in_req_t make_ray(input int ox, input int oy, input int oz,
                                                 input int dx, input int dy, input int dz);
    sphi_pkg::in_req_t ray;
    ray.origin_x = ox[15:0]; ray.origin_y = oy[15:0]; ray.origin_z = oz[15:0];
    ray.dir_x    = dx[15:0]; ray.dir_y    = dy[15:0]; ray.dir_z    = dz[15:0];
    return ray;
  endfunction

  // Random coordinate: mostly small Q4.12 values so that rays meet the
  // sphere often, sometimes full range so that every bit toggles.
  function automatic int rand_coord(input int span);
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // A ray aimed near the sphere centre from a random start point.
  function automatic sphi_pkg::in_req_t aimed_ray(input int span);
    int ox, oy, oz;
    ox = rand_coord(span); oy = rand_coord(span); oz = rand_coord(span);
    return make_ray(ox, oy, oz,
                    -ox + rand_coord(span / 4), -oy + rand_coord(span / 4),
                    -oz + rand_coord(span / 4));
  endfunction

  task automatic wait_drained();
    while (ray_queue.size() > 0 || start || hit_queue.size() > 0) @(posedge clk);
    // Every ray gives a result, so nothing is still in flight here.
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input sphi_pkg::cfg_idx_t sel,
                           input logic [sphi_pkg::RSQ_W-1:0] val);
    cfg_sel = sel;
    cfg_val = val;
    cfg_go  = 1'b1;
    @(posedge clk);
    while (!cfg_done) @(posedge clk);
    cfg_go = 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int span);
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) ray_queue.push_back(aimed_ray(span));
      else ray_queue.push_back(make_ray(rand_coord(32767), rand_coord(32767),
                                        rand_coord(32767), rand_coord(32767),
                                        rand_coord(32767), rand_coord(32767)));
    end
    wait_drained();
  endtask

  // Sequence: reset, directed rays, then random phases under several settings.
  initial begin
    errors       = 0;
    drive_enable = 1'b0;
    idle_enable  = 1'b1;
    cfg_go       = 1'b0;
    cfg_sel      = sphi_pkg::CFG_RADIUS_SQUARED;
    cfg_val      = '0;
    model_rsq    = sphi_pkg::RSQ_RESET;
    model_eps    = sphi_pkg::MIN_RESET;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays under the reset radius and epsilon. One unit is 4096.
    ray_queue.push_back(make_ray(0, 0, -8192, 0, 0, 4096));       // plain hit at 1
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 4096));           // origin inside
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));              // zero direction
    ray_queue.push_back(make_ray(8192, 0, -8192, 0, 0, 4096));    // discriminant negative
    ray_queue.push_back(make_ray(4096, 0, -8192, 0, 0, 4096));    // grazing, zero root gap
    ray_queue.push_back(make_ray(0, 0, 8192, 0, 0, 4096));        // sphere behind the ray
    ray_queue.push_back(make_ray(0, 0, 4096, 0, 0, 4096));        // both roots not positive
    ray_queue.push_back(make_ray(0, 0, -32768, 0, 0, 1));         // large root, below saturation
    ray_queue.push_back(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
    ray_queue.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768));
    ray_queue.push_back(make_ray(-32768, 32767, -1, 1, -1, 32767));
    ray_queue.push_back(make_ray(0, 0, -4097, 0, 0, 4096));       // just outside the surface
    ray_queue.push_back(make_ray(0, 0, -4096, 0, 0, 4096));       // on the surface
    ray_queue.push_back(make_ray(0, 0, -32768, 0, 0, 32767));
    drive_enable = 1'b1;
    wait_drained();

    // Random rays under the reset settings; each phase waits until all results are in.
    random_phase(150, 8192);

    write_reg(sphi_pkg::CFG_RADIUS_SQUARED, 32'hFFFF_FFFF);
    write_reg(sphi_pkg::CFG_MIN_DISTANCE, 32'h0000_FFFF);
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 4096));           // near root behind the origin
    random_phase(150, 32767);

    write_reg(sphi_pkg::CFG_RADIUS_SQUARED, 32'h0000_0000);
    write_reg(sphi_pkg::CFG_MIN_DISTANCE, 32'h0000_0000);
    random_phase(100, 8192);

    write_reg(sphi_pkg::CFG_RADIUS_SQUARED, 32'h0400_0000 + $urandom_range(0, 32'h00FF_FFFF));
    write_reg(sphi_pkg::CFG_MIN_DISTANCE, $urandom_range(0, 65535));
    random_phase(200, 16384);

    write_reg(sphi_pkg::CFG_RADIUS_SQUARED, 32'h0000_0001);
    write_reg(sphi_pkg::CFG_MIN_DISTANCE, 32'h0000_0007);
    random_phase(50, 4096);

    // Last part: back to back rays, no idling.
    write_reg(sphi_pkg::CFG_RADIUS_SQUARED, sphi_pkg::RSQ_RESET);
    idle_enable = 1'b0;
    random_phase(150, 8192);

    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/sphi_pkg.sv
design/sphi_sqrt_cell.sv
design/sphi_div_cell.sv
design/ray_unit_sphere_intersect.sv
sim/ray_unit_sphere_intersect_tb.sv
